### rtl/zero_run_mtf_decoder_core_macros.svh
// assertion macros shared by the decoder modules
`ifndef ZERO_RUN_MTF_DECODER_CORE_MACROS_SVH
`define ZERO_RUN_MTF_DECODER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ZRMD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zrmd implication check failed");

// next-cycle implication, checked outside reset
`define ZRMD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zrmd next-cycle check failed");

`endif

### rtl/zrmd_pkg.sv
// types and constants shared by the zero-run and move-to-front decoder
package zrmd_pkg;

  localparam int TableDepth = 256;
  localparam int IdxW       = 8;

  typedef logic [2:0] status_code_t;
  typedef logic [1:0] rd_sel_t;
  typedef logic [1:0] out_sel_t;

  localparam status_code_t StatusOk        = 3'd0;
  localparam status_code_t StatusRunDigits = 3'd1;
  localparam status_code_t StatusRunLong   = 3'd2;
  localparam status_code_t StatusTooLong   = 3'd3;
  localparam status_code_t StatusTruncEsc  = 3'd4;
  localparam status_code_t StatusBadEsc    = 3'd5;
  localparam status_code_t StatusFinalLong = 3'd6;
  localparam status_code_t StatusShort     = 3'd7;

  localparam rd_sel_t RdIdx = 2'd0;
  localparam rd_sel_t RdJm1 = 2'd1;
  localparam rd_sel_t RdJm2 = 2'd2;

  localparam out_sel_t OutFlush = 2'd0;
  localparam out_sel_t OutLit   = 2'd1;
  localparam out_sel_t OutFinal = 2'd2;
  localparam out_sel_t OutStat  = 2'd3;

  typedef struct packed {
    logic         accept;
    logic         new_section;
    logic         set_failed;
    logic         clear_esc;
    logic         set_esc;
    logic         digit;
    logic         run_clear;
    logic         br_sub_rl;
    logic         br_dec;
    logic         idx_load_esc;
    logic         idx_load_lit;
    logic         err_load;
    status_code_t err_code;
    logic         sym_from_front;
    logic         sym_from_mem;
    rd_sel_t      rd_sel;
    logic         j_load;
    logic         shift_step;
    logic         front_from_sym;
    logic         out_load;
    out_sel_t     out_sel;
  } cmd_t;

  typedef struct packed {
    logic is_digit;
    logic lt_254;
    logic is_255;
    logic eos;
    logic esc;
    logic failed;
    logic k_nz;
    logic k_last;
    logic rl_ge_br;
    logic rl_gt_br;
    logic rl_eq_br;
    logic br_zero;
    logic idx_zero;
    logic j_one;
    logic out_free;
  } stat_t;

endpackage

### rtl/zrmd_datapath.sv
// datapath: run accumulator, byte count, table memory with shift sweep, output register
module zrmd_datapath #(
  parameter int MAX_SECTION = 32768
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [15:0]     cfg_wr_data,
  input  logic [7:0]      code_byte,
  input  logic            end_of_section,
  input  zrmd_pkg::cmd_t  cmd,
  output zrmd_pkg::stat_t stat,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      symbol,
  output logic [15:0]     repeat_res,
  output logic [2:0]      status,
  output logic            section_done
);
  import zrmd_pkg::*;
`include "zero_run_mtf_decoder_core_macros.svh"

  localparam logic [16:0] MaxLen = 17'(MAX_SECTION);

  logic [15:0]     sec_len;
  logic [15:0]     eff_len;
  logic            open;
  logic [7:0]      byte_q;
  logic            eos_q;
  logic [15:0]     br;
  logic [31:0]     acc;
  logic [4:0]      k;
  logic            esc;
  logic            failed;
  status_code_t    err;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] j;
  logic [7:0]      front;
  logic [7:0]      sym;

  logic [7:0]            mem [TableDepth];
  logic [TableDepth-1:0] valid_bits;
  logic [IdxW-1:0]       raddr;
  logic [7:0]            rd_data;
  logic                  rd_valid;
  logic [IdxW-1:0]       rd_addr_q;
  logic [7:0]            rd_value;
  logic [7:0]            wdata;

  logic [32:0] run_len;
  logic [32:0] br_ext;

  logic [7:0]  o_sym;
  logic [15:0] o_rep;
  logic [2:0]  o_st;
  logic        o_done;

  assign eff_len  = ({1'b0, sec_len} > MaxLen) ? MaxLen[15:0] : sec_len;
  assign run_len  = {1'b0, acc} + (33'd1 << k) - 33'd1;
  assign br_ext   = {17'd0, br};
  assign rd_value = rd_valid ? rd_data : rd_addr_q;
  assign wdata    = (j == IdxW'(1)) ? front : rd_value;

  always_comb begin
    case (cmd.rd_sel)
      RdIdx:   raddr = idx;
      RdJm1:   raddr = j - IdxW'(1);
      RdJm2:   raddr = j - IdxW'(2);
      default: raddr = idx;
    endcase
  end

  assign stat.is_digit = (byte_q < 8'd2);
  assign stat.lt_254   = (byte_q < 8'd254);
  assign stat.is_255   = (byte_q == 8'd255);
  assign stat.eos      = eos_q;
  assign stat.esc      = esc;
  assign stat.failed   = failed;
  assign stat.k_nz     = (k != 5'd0);
  assign stat.k_last   = (k == 5'd31);
  assign stat.rl_ge_br = (run_len >= br_ext);
  assign stat.rl_gt_br = (run_len > br_ext);
  assign stat.rl_eq_br = (run_len == br_ext);
  assign stat.br_zero  = (br == 16'd0);
  assign stat.idx_zero = (idx == IdxW'(0));
  assign stat.j_one    = (j == IdxW'(1));
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sec_len <= 16'd32768;
    end else if (cfg_wr_en) begin
      sec_len <= cfg_wr_data;
    end
  end

  // table memory, entry 0 lives in front
  always_ff @(posedge clk) begin
    if (cmd.shift_step) begin
      mem[j] <= wdata;
    end
    rd_data   <= mem[raddr];
    rd_valid  <= valid_bits[raddr];
    rd_addr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (cmd.new_section) begin
      valid_bits <= '0;
    end else if (cmd.shift_step) begin
      valid_bits[j] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_q <= code_byte;
      eos_q  <= end_of_section;
      if (!open) begin
        br <= eff_len;
      end
    end
    if (cmd.br_sub_rl) begin
      br <= br - run_len[15:0];
    end
    if (cmd.br_dec) begin
      br <= br - 16'd1;
    end
    if (cmd.err_load) begin
      err <= cmd.err_code;
    end
    if (cmd.idx_load_esc) begin
      idx <= byte_q;
    end
    if (cmd.idx_load_lit) begin
      idx <= byte_q - 8'd1;
    end
    if (cmd.j_load) begin
      j <= idx;
    end else if (cmd.shift_step) begin
      j <= j - IdxW'(1);
    end
    if (cmd.sym_from_front) begin
      sym <= front;
    end
    if (cmd.sym_from_mem) begin
      sym <= rd_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open   <= 1'b0;
      acc    <= 32'd0;
      k      <= 5'd0;
      esc    <= 1'b0;
      failed <= 1'b0;
      front  <= 8'd0;
    end else begin
      if (cmd.accept) begin
        open <= 1'b1;
      end
      if (cmd.digit) begin
        acc <= acc | ({31'd0, byte_q[0]} << k);
        k   <= k + 5'd1;
      end
      if (cmd.run_clear) begin
        acc <= 32'd0;
        k   <= 5'd0;
      end
      if (cmd.set_esc) begin
        esc <= 1'b1;
      end
      if (cmd.clear_esc) begin
        esc <= 1'b0;
      end
      if (cmd.set_failed) begin
        failed <= 1'b1;
      end
      if (cmd.front_from_sym) begin
        front <= sym;
      end
      if (cmd.new_section) begin
        open   <= 1'b0;
        acc    <= 32'd0;
        k      <= 5'd0;
        esc    <= 1'b0;
        failed <= 1'b0;
        front  <= 8'd0;
      end
    end
  end

  always_comb begin
    case (cmd.out_sel)
      OutFlush: begin
        o_sym  = front;
        o_rep  = run_len[15:0];
        o_st   = StatusOk;
        o_done = 1'b0;
      end
      OutLit: begin
        o_sym  = sym;
        o_rep  = 16'd1;
        o_st   = StatusOk;
        o_done = eos_q && (br == 16'd0);
      end
      OutFinal: begin
        o_sym  = front;
        o_rep  = run_len[15:0];
        o_st   = StatusOk;
        o_done = (run_len == br_ext);
      end
      OutStat: begin
        o_sym  = 8'd0;
        o_rep  = 16'd0;
        o_st   = err;
        o_done = 1'b1;
      end
      default: begin
        o_sym  = 8'd0;
        o_rep  = 16'd0;
        o_st   = err;
        o_done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      symbol       <= o_sym;
      repeat_res   <= o_rep;
      status       <= o_st;
      section_done <= o_done;
    end
  end

  // a flushed run always leaves room for the literal behind it
  `ZRMD_ASSERT_IMP(a_flush_fits, cmd.out_load && cmd.out_sel == OutFlush, !stat.rl_ge_br)
  `ZRMD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(symbol))
  `ZRMD_ASSERT_IMP(a_shift_j, cmd.shift_step, j != IdxW'(0))

endmodule

### rtl/zrmd_ctrl.sv
// controller state machine sequencing decode, run flush, table sweep and results
module zrmd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  zrmd_pkg::stat_t stat,
  output zrmd_pkg::cmd_t  cmd
);
  import zrmd_pkg::*;
`include "zero_run_mtf_decoder_core_macros.svh"

  localparam logic [3:0] StIdle     = 4'd0;
  localparam logic [3:0] StDecode   = 4'd1;
  localparam logic [3:0] StFlush    = 4'd2;
  localparam logic [3:0] StLitChk   = 4'd3;
  localparam logic [3:0] StLitRd    = 4'd4;
  localparam logic [3:0] StLitSym   = 4'd5;
  localparam logic [3:0] StLitShift = 4'd6;
  localparam logic [3:0] StLitOut   = 4'd7;
  localparam logic [3:0] StEndChk   = 4'd8;
  localparam logic [3:0] StErr      = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != StIdle);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RdIdx;
    state_next = state;
    case (state)
      StIdle: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = StDecode;
        end
      end
      StDecode: begin
        if (stat.failed) begin
          cmd.new_section = stat.eos;
          state_next      = StIdle;
        end else if (stat.esc) begin
          cmd.clear_esc = 1'b1;
          if (stat.lt_254) begin
            cmd.err_load = 1'b1;
            cmd.err_code = StatusBadEsc;
            state_next   = StErr;
          end else begin
            cmd.idx_load_esc = 1'b1;
            state_next       = StLitRd;
          end
        end else if (stat.is_digit) begin
          cmd.digit = 1'b1;
          if (stat.k_last) begin
            cmd.err_load = 1'b1;
            cmd.err_code = StatusRunDigits;
            state_next   = StErr;
          end else begin
            state_next = stat.eos ? StEndChk : StIdle;
          end
        end else begin
          state_next = stat.k_nz ? StFlush : StLitChk;
        end
      end
      StFlush: begin
        if (stat.rl_ge_br) begin
          cmd.err_load = 1'b1;
          cmd.err_code = StatusRunLong;
          state_next   = StErr;
        end else if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = OutFlush;
          cmd.br_sub_rl = 1'b1;
          cmd.run_clear = 1'b1;
          state_next    = StLitChk;
        end
      end
      StLitChk: begin
        if (stat.br_zero) begin
          cmd.err_load = 1'b1;
          cmd.err_code = StatusTooLong;
          state_next   = StErr;
        end else begin
          cmd.br_dec = 1'b1;
          if (stat.is_255) begin
            if (stat.eos) begin
              cmd.err_load = 1'b1;
              cmd.err_code = StatusTruncEsc;
              state_next   = StErr;
            end else begin
              cmd.set_esc = 1'b1;
              state_next  = StIdle;
            end
          end else begin
            cmd.idx_load_lit = 1'b1;
            state_next       = StLitRd;
          end
        end
      end
      StLitRd: begin
        if (stat.idx_zero) begin
          cmd.sym_from_front = 1'b1;
          state_next         = StLitOut;
        end else begin
          cmd.j_load = 1'b1;
          state_next = StLitSym;
        end
      end
      StLitSym: begin
        cmd.sym_from_mem = 1'b1;
        cmd.rd_sel       = RdJm1;
        state_next       = StLitShift;
      end
      StLitShift: begin
        cmd.shift_step = 1'b1;
        cmd.rd_sel     = RdJm2;
        if (stat.j_one) begin
          cmd.front_from_sym = 1'b1;
          state_next         = StLitOut;
        end
      end
      StLitOut: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OutLit;
          if (stat.eos) begin
            if (stat.br_zero) begin
              cmd.new_section = 1'b1;
              state_next      = StIdle;
            end else begin
              cmd.err_load = 1'b1;
              cmd.err_code = StatusShort;
              state_next   = StErr;
            end
          end else begin
            state_next = StIdle;
          end
        end
      end
      StEndChk: begin
        if (!stat.k_nz) begin
          cmd.err_load = 1'b1;
          cmd.err_code = stat.br_zero ? StatusOk : StatusShort;
          state_next   = StErr;
        end else if (stat.rl_gt_br) begin
          cmd.err_load = 1'b1;
          cmd.err_code = StatusFinalLong;
          state_next   = StErr;
        end else if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = OutFinal;
          cmd.br_sub_rl = 1'b1;
          if (stat.rl_eq_br) begin
            cmd.new_section = 1'b1;
            state_next      = StIdle;
          end else begin
            cmd.err_load = 1'b1;
            cmd.err_code = StatusShort;
            state_next   = StErr;
          end
        end
      end
      StErr: begin
        if (stat.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_sel     = OutStat;
          cmd.new_section = stat.eos;
          cmd.set_failed  = !stat.eos;
          state_next      = StIdle;
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  `ZRMD_ASSERT_NXT(a_accept_decode, in_valid && !in_stall, state == StDecode)
  `ZRMD_ASSERT_IMP(a_load_free, cmd.out_load, stat.out_free)
  `ZRMD_ASSERT_NXT(a_shift_end, state == StLitShift && stat.j_one, state == StLitOut)

endmodule

### rtl/zero_run_mtf_decoder_core.sv
// occupancy: a literal beat steps through decode, literal check, table read, symbol fetch,
// shift sweep and output; an escaped index skips the literal check; a run flush before a
// literal adds the flush step, and any output stall holds the beat longer
// throughput: a new code beat is taken only when idle, after the last one is through; the
// table shift sweep runs through the single write port of the table memory, one entry a cycle
// reset: synchronous rst clears control and table valid bits, length register to 32768
module zero_run_mtf_decoder_core #(
  parameter int MAX_SECTION = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  code_byte,
  input  logic        end_of_section,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  symbol,
  output logic [15:0] repeat_res,
  output logic [2:0]  status,
  output logic        section_done
);
  import zrmd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  zrmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  zrmd_datapath #(
    .MAX_SECTION (MAX_SECTION)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .code_byte      (code_byte),
    .end_of_section (end_of_section),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .symbol         (symbol),
    .repeat_res     (repeat_res),
    .status         (status),
    .section_done   (section_done)
  );

endmodule
